FILE: src/dcd_pkg.sv
// Shared constants and types for the damper crossing detector.
// Depends on nothing; imported by the top level.
package dcd_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int DELAY_LEN_DEF = 8;

    localparam int KEY_W      = 4;
    localparam int POS_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int FVEL_W     = 15;
    localparam int VEL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Velocity: |d| * gain / 64, rounded half away from zero, capped at one in Q1.14
    localparam int VEL_SHIFT = 6;
    localparam int VEL_MAX   = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_THRESHOLD  = 3'd1,
        REG_LOW_THRESH = 3'd2,
        REG_GAIN       = 3'd3,
        REG_FORCED_VEL = 3'd4
    } cfg_reg_t;

    localparam logic              ENABLE_RST     = 1'b1;
    localparam logic [POS_W-1:0]  THRESHOLD_RST  = 12'd2048;
    localparam logic [POS_W-1:0]  LOW_THRESH_RST = 12'd1638;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd256;
    localparam logic [FVEL_W-1:0] FORCED_VEL_RST = 15'd3277;

endpackage

FILE: src/dcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the delay line and the per-key state.
module dcd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/damper_crossing_detector.sv
// Damper crossing detector top level: pipeline, per-key state and config registers.
// Depends on dcd_pkg and dcd_ram.

// One word is accepted per clock cycle when the output side keeps up; each word
// passes in turn the delay-line and key-state read, the crossing check and
// multiply, and the rounding and output register. The throughput is set by the
// read-modify-write of the two RAMs, which is forwarded between back-to-back
// words for the same key. After reset the block clears both RAMs, one entry per
// cycle, over all CHANNELS * 2**ceil(log2(DELAY_LEN)) delay-line entries (128 at
// the defaults); no input word is accepted during that pass, though
// configuration writes are. Keys at or above CHANNELS give no event and zero velocity.
module damper_crossing_detector #(
    parameter int CHANNELS  = dcd_pkg::CHANNELS_DEF,
    parameter int DELAY_LEN = dcd_pkg::DELAY_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dcd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dcd_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dcd_pkg::KEY_W-1:0]            key,
    input  logic [dcd_pkg::POS_W-1:0]            position,
    input  logic                                 hammer_strike,
    input  logic                                 frame_end,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dcd_pkg::KEY_W-1:0]            key_out,
    output logic                                 damp_event,
    output logic                                 lift_event,
    output logic                                 forced,
    output logic signed [dcd_pkg::VEL_W-1:0]     velocity
);

    import dcd_pkg::*;

    localparam int SLOT_W   = $clog2(DELAY_LEN);
    localparam int KEY_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DL_DEPTH = CHANNELS * (2 ** SLOT_W);
    localparam int DL_AW    = $clog2(DL_DEPTH);
    localparam int CNT_W    = $clog2(2 * DELAY_LEN + 1);
    localparam int PROD_W   = POS_W + GAIN_W;
    localparam int MAG_W    = FVEL_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DELAY_LEN - 1);
    localparam logic [CNT_W-1:0]  RELOAD    = CNT_W'(2 * DELAY_LEN);
    localparam logic [DL_AW:0]    CH_LIM    = (DL_AW + 1)'(CHANNELS);
    localparam logic [DL_AW-1:0]  CLR_LAST  = DL_AW'(DL_DEPTH - 1);
    localparam logic [7:0]        KEY_LIM   = 8'(CHANNELS);
    localparam logic [PROD_W:0]   RND_BIAS  = (PROD_W + 1)'(1 << (VEL_SHIFT - 1));
    localparam logic [MAG_W-1:0]  MAG_MAX   = MAG_W'(VEL_MAX);

    typedef struct packed {
        logic [CNT_W-1:0] up_cnt;
        logic [CNT_W-1:0] down_cnt;
        logic             latched;
    } key_state_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // configuration
    logic              enable_reg;
    logic [POS_W-1:0]  thr_reg;
    logic [POS_W-1:0]  low_thr_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [FVEL_W-1:0] fvel_reg;

    state_t           state_reg, state_next;
    logic [DL_AW-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] wp_reg;

    // stage 1: RAM data arrives
    logic              s1_valid_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic              s1_in_range_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic              s1_strike_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              fwd_dl_reg;
    logic [POS_W-1:0]  fwd_pos_reg;
    logic              fwd_ks_reg;
    key_state_t        fwd_ks_data_reg;

    // stage 2: product registered
    logic              s2_valid_reg;
    logic [KEY_W-1:0]  s2_key_reg;
    logic              s2_lift_reg;
    logic              s2_damp_reg;
    logic              s2_forced_reg;
    logic              s2_neg_reg;
    logic [PROD_W-1:0] s2_prod_reg;

    // output register
    logic                    out_valid_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic                    out_damp_reg;
    logic                    out_lift_reg;
    logic                    out_forced_reg;
    logic signed [VEL_W-1:0] out_vel_reg;

    logic adv_out, adv2, adv1, accept, s1_fire, s2_fire, clearing;
    logic [7:0]        key_ext;
    logic              in_range;
    logic [SLOT_W-1:0] rd_slot;

    logic [DL_AW-1:0]  dl_raddr, dl_waddr;
    logic [POS_W-1:0]  dl_wdata, dl_rdata;
    logic              dl_we;
    logic [KEY_AW-1:0] ks_raddr, ks_waddr;
    key_state_t        ks_wdata, ks_rdata, ks_cur, ks_new;
    logic              ks_we;

    logic [POS_W-1:0]  then_pos, diff_mag;
    logic              cross_up, cross_down, lift_c, damp_c, forced_c, neg_c;

    logic [PROD_W:0]   rnd_sum;
    logic [MAG_W-1:0]  sat_mag, fvel_mag, mag_sel;
    logic signed [VEL_W-1:0] vel_c;

    // ---------------- handshake ----------------
    assign clearing  = (state_reg == ST_CLEAR);
    assign adv_out   = !out_valid_reg || out_ready;
    assign adv2      = !s2_valid_reg || adv_out;
    assign adv1      = !s1_valid_reg || adv2;
    assign in_ready  = !clearing && adv1;
    assign accept    = in_valid && in_ready;
    assign s1_fire   = s1_valid_reg && adv2;
    assign s2_fire   = s2_valid_reg && adv_out;
    assign cfg_ready = 1'b1;

    assign key_ext  = {4'b0000, key};
    assign in_range = (key_ext < KEY_LIM);
    assign rd_slot  = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= ENABLE_RST;
            thr_reg     <= THRESHOLD_RST;
            low_thr_reg <= LOW_THRESH_RST;
            gain_reg    <= GAIN_RST;
            fvel_reg    <= FORCED_VEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg  <= cfg_data[0];
                REG_THRESHOLD:  thr_reg     <= cfg_data[POS_W-1:0];
                REG_LOW_THRESH: low_thr_reg <= cfg_data[POS_W-1:0];
                REG_GAIN:       gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_FORCED_VEL: fvel_reg    <= cfg_data[FVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- clearing pass and pointer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == CLR_LAST) state_next = ST_RUN;
            ST_RUN:   state_next = ST_RUN;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept && enable_reg && frame_end)
            begin
                wp_reg <= rd_slot;
            end
        end
    end

    // ---------------- RAMs ----------------
    assign dl_raddr = DL_AW'({key_ext[KEY_AW-1:0], rd_slot});
    assign ks_raddr = key_ext[KEY_AW-1:0];

    always_comb
    begin
        if (clearing)
        begin
            dl_we    = 1'b1;
            dl_waddr = clr_cnt_reg;
            dl_wdata = '0;
            ks_we    = ({1'b0, clr_cnt_reg} < CH_LIM);
            ks_waddr = clr_cnt_reg[KEY_AW-1:0];
            ks_wdata = '{up_cnt: RELOAD, down_cnt: RELOAD, latched: 1'b0};
        end
        else
        begin
            dl_we    = s1_fire && s1_in_range_reg && enable_reg;
            dl_waddr = DL_AW'({s1_key_reg[KEY_AW-1:0], s1_slot_reg});
            dl_wdata = s1_pos_reg;
            ks_we    = s1_fire && s1_in_range_reg;
            ks_waddr = s1_key_reg[KEY_AW-1:0];
            ks_wdata = ks_new;
        end
    end

    dcd_ram #(.WIDTH(POS_W), .DEPTH(DL_DEPTH)) u_delay_ram (
        .clk     (clk),
        .wr_en   (dl_we),
        .wr_addr (dl_waddr),
        .wr_data (dl_wdata),
        .rd_en   (accept),
        .rd_addr (dl_raddr),
        .rd_data (dl_rdata)
    );

    dcd_ram #(.WIDTH($bits(key_state_t)), .DEPTH(CHANNELS)) u_state_ram (
        .clk     (clk),
        .wr_en   (ks_we),
        .wr_addr (ks_waddr),
        .wr_data (ks_wdata),
        .rd_en   (accept),
        .rd_addr (ks_raddr),
        .rd_data (ks_rdata)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Forward the word leaving stage 1 when it writes what this word reads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg      <= key;
            s1_in_range_reg <= in_range;
            s1_pos_reg      <= position;
            s1_strike_reg   <= hammer_strike;
            s1_slot_reg     <= wp_reg;
            fwd_dl_reg      <= dl_we && (s1_key_reg == key) && (s1_slot_reg == rd_slot);
            fwd_pos_reg     <= s1_pos_reg;
            fwd_ks_reg      <= ks_we && (s1_key_reg == key);
            fwd_ks_data_reg <= ks_new;
        end
    end

    assign then_pos = fwd_dl_reg ? fwd_pos_reg : dl_rdata;
    assign ks_cur   = fwd_ks_reg ? fwd_ks_data_reg : ks_rdata;

    assign cross_up   = (s1_pos_reg >= thr_reg) && (then_pos < thr_reg);
    assign cross_down = (s1_pos_reg <= thr_reg) && (then_pos > thr_reg);
    assign neg_c      = (s1_pos_reg < then_pos);
    assign diff_mag   = neg_c ? (then_pos - s1_pos_reg) : (s1_pos_reg - then_pos);

    always_comb
    begin
        ks_new   = ks_cur;
        lift_c   = 1'b0;
        damp_c   = 1'b0;
        forced_c = 1'b0;
        if (enable_reg)
        begin
            if (ks_cur.up_cnt != '0)
            begin
                ks_new.up_cnt = ks_cur.up_cnt - 1'b1;
            end
            else if (cross_up)
            begin
                lift_c        = 1'b1;
                ks_new.up_cnt = RELOAD;
            end
            if (ks_cur.down_cnt != '0)
            begin
                ks_new.down_cnt = ks_cur.down_cnt - 1'b1;
            end
            else if (cross_down)
            begin
                damp_c          = 1'b1;
                ks_new.down_cnt = RELOAD;
            end
        end
        // hammer latch: a struck note whose damper never fell is damped here
        if (!ks_cur.latched)
        begin
            ks_new.latched = s1_strike_reg;
        end
        else if (damp_c)
        begin
            ks_new.latched = 1'b0;
        end
        else if (s1_pos_reg < low_thr_reg)
        begin
            ks_new.latched = 1'b0;
            forced_c       = 1'b1;
        end
        if (!s1_in_range_reg)
        begin
            lift_c   = 1'b0;
            damp_c   = 1'b0;
            forced_c = 1'b0;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_key_reg    <= s1_key_reg;
            s2_lift_reg   <= lift_c && !forced_c;
            s2_damp_reg   <= damp_c || forced_c;
            s2_forced_reg <= forced_c;
            s2_neg_reg    <= neg_c && !forced_c;
            s2_prod_reg   <= PROD_W'(diff_mag) * PROD_W'(gain_reg);
        end
    end

    assign rnd_sum  = {1'b0, s2_prod_reg} + RND_BIAS;
    assign sat_mag  = (rnd_sum[PROD_W:VEL_SHIFT] > (PROD_W + 1 - VEL_SHIFT)'(VEL_MAX))
                      ? MAG_MAX : rnd_sum[VEL_SHIFT+MAG_W-1:VEL_SHIFT];
    assign fvel_mag = (fvel_reg > MAG_MAX) ? MAG_MAX : fvel_reg;

    always_comb
    begin
        if (s2_forced_reg)
        begin
            mag_sel = fvel_mag;
        end
        else if (s2_lift_reg || s2_damp_reg)
        begin
            mag_sel = sat_mag;
        end
        else
        begin
            mag_sel = '0;
        end
        vel_c = s2_neg_reg ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_key_reg    <= s2_key_reg;
            out_damp_reg   <= s2_damp_reg;
            out_lift_reg   <= s2_lift_reg;
            out_forced_reg <= s2_forced_reg;
            out_vel_reg    <= vel_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_out    = out_key_reg;
    assign damp_event = out_damp_reg;
    assign lift_event = out_lift_reg;
    assign forced     = out_forced_reg;
    assign velocity   = out_vel_reg;

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("input word accepted during RAM clearing pass");

    a_lift_damp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(lift_event && damp_event))
        else $error("lift and damp reported on one word");

    a_forced_is_damp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && forced) |-> (damp_event && !lift_event && velocity >= 0))
        else $error("forced event without plain damp");

    a_idle_velocity_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !damp_event && !lift_event) |-> (velocity == 0))
        else $error("velocity nonzero without event");

    a_fwd_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && !s1_fire) |-> 1'b0)
        else $error("word accepted while stage 1 holds");

endmodule

FILE: sim/damper_crossing_detector_test.sv
// Self-checking testbench for damper_crossing_detector: random frames of key samples
// against an in-file predictor, under several register settings and handshake stalls.
// Depends on dcd_pkg and the damper_crossing_detector RTL.
`timescale 1ns / 100ps

module damper_crossing_detector_test;

    import dcd_pkg::*;

    localparam int CHANNELS     = CHANNELS_DEF;
    localparam int DELAY_LEN    = DELAY_LEN_DEF;
    localparam int BLOCK_RELOAD = 2 * DELAY_LEN;
    localparam int PHASE_WORDS  = 145;
    localparam int MAX_REPORTS  = 50;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
        logic             hammer_strike;
        logic             frame_end;
    } sample_word_t;

    typedef struct {
        logic [KEY_W-1:0]        key;
        logic                    damp;
        logic                    lift;
        logic                    forced;
        logic signed [VEL_W-1:0] vel;
    } damper_event_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [KEY_W-1:0] key = '0;
    logic [POS_W-1:0] position = '0;
    logic             hammer_strike = 1'b0;
    logic             frame_end = 1'b0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [KEY_W-1:0]        key_out;
    logic                    damp_event;
    logic                    lift_event;
    logic                    forced;
    logic signed [VEL_W-1:0] velocity;

    damper_crossing_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key           (key),
        .position      (position),
        .hammer_strike (hammer_strike),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_out       (key_out),
        .damp_event    (damp_event),
        .lift_event    (lift_event),
        .forced        (forced),
        .velocity      (velocity)
    );

    // Predictor copy of the registers
    logic              en_q;
    logic [POS_W-1:0]  thr_q;
    logic [POS_W-1:0]  low_q;
    logic [GAIN_W-1:0] gain_q;
    logic [FVEL_W-1:0] fvel_q;

    // Predictor copy of the per-key state
    logic [POS_W-1:0] delay_mem [CHANNELS][DELAY_LEN];
    int               wr_ptr;
    int               up_hold [CHANNELS];
    int               down_hold [CHANNELS];
    logic             strike_latch [CHANNELS];

    // Stimulus trajectory per key: side of the threshold and frames left on it
    logic trace_high [CHANNELS];
    int   trace_hold [CHANNELS];

    sample_word_t  pending_samples[$];
    damper_event_t expected_events[$];

    int send_gap_pct;
    int recv_stall_pct;
    int error_count;
    int words_sent;
    int results_checked;
    int lifts_seen;
    int damps_seen;
    int forced_seen;
    int settings_run;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [VEL_W-1:0] crossing_slope(logic [POS_W-1:0] now_pos,
                                                               logic [POS_W-1:0] old_pos);
        longint diff;
        longint mag;
        diff = longint'(now_pos) - longint'(old_pos);
        mag  = (diff < 0 ? -diff : diff) * longint'(gain_q);
        mag  = (mag + (1 << (VEL_SHIFT - 1))) / (1 << VEL_SHIFT);
        if (mag > VEL_MAX)
            mag = VEL_MAX;
        return (diff < 0) ? VEL_W'(-mag) : VEL_W'(mag);
    endfunction

    task automatic reset_predictor();
        en_q   = ENABLE_RST;
        thr_q  = THRESHOLD_RST;
        low_q  = LOW_THRESH_RST;
        gain_q = GAIN_RST;
        fvel_q = FORCED_VEL_RST;
        wr_ptr = 0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            for (int s = 0; s < DELAY_LEN; s++)
                delay_mem[k][s] = '0;
            up_hold[k]      = BLOCK_RELOAD;
            down_hold[k]    = BLOCK_RELOAD;
            strike_latch[k] = 1'b0;
            trace_high[k]   = 1'b0;
            trace_hold[k]   = 0;
        end
    endtask

    task automatic predict_crossing(input sample_word_t w);
        damper_event_t r;
        logic [POS_W-1:0] older;
        int k;
        k        = int'(w.key);
        r.key    = w.key;
        r.damp   = 1'b0;
        r.lift   = 1'b0;
        r.forced = 1'b0;
        r.vel    = '0;
        if (k < CHANNELS)
        begin
            if (en_q)
            begin
                older = delay_mem[k][(wr_ptr + 1) % DELAY_LEN];
                delay_mem[k][wr_ptr] = w.position;
                if (up_hold[k] == 0)
                begin
                    if (w.position >= thr_q && older < thr_q)
                    begin
                        r.lift     = 1'b1;
                        r.vel      = crossing_slope(w.position, older);
                        up_hold[k] = BLOCK_RELOAD;
                    end
                end
                else
                    up_hold[k]--;
                if (down_hold[k] == 0)
                begin
                    if (w.position <= thr_q && older > thr_q)
                    begin
                        r.damp       = 1'b1;
                        r.vel        = crossing_slope(w.position, older);
                        down_hold[k] = BLOCK_RELOAD;
                    end
                end
                else
                    down_hold[k]--;
            end
            // Latch a strike; release it on a real damp, or force one when the damper stayed up
            if (!strike_latch[k])
            begin
                if (w.hammer_strike)
                    strike_latch[k] = 1'b1;
            end
            else if (r.damp)
                strike_latch[k] = 1'b0;
            else if (w.position < low_q)
            begin
                strike_latch[k] = 1'b0;
                r.damp   = 1'b1;
                r.forced = 1'b1;
                r.lift   = 1'b0;
                r.vel    = (fvel_q > VEL_MAX) ? VEL_W'(VEL_MAX) : VEL_W'(fvel_q);
            end
        end
        if (en_q && w.frame_end)
            wr_ptr = (wr_ptr + 1) % DELAY_LEN;
        expected_events.push_back(r);
    endtask

    // Driver: hold the word until accepted, then offer the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_crossing('{key, position, hammer_strike, frame_end});
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    sample_word_t w;
                    w = pending_samples.pop_front();
                    key           <= w.key;
                    position      <= w.position;
                    hammer_strike <= w.hammer_strike;
                    frame_end     <= w.frame_end;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with no word pending, expected none, actual key %0d",
                                 $time, key_out);
                end
                else
                begin
                    damper_event_t e;
                    e = expected_events.pop_front();
                    report_field("key_out", e.key, key_out);
                    report_field("damp_event", e.damp, damp_event);
                    report_field("lift_event", e.lift, lift_event);
                    report_field("forced", e.forced, forced);
                    report_field("velocity", e.vel, velocity);
                    results_checked++;
                    lifts_seen  += e.lift;
                    damps_seen  += e.damp;
                    forced_seen += e.forced;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_events.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE:     en_q   = val[0];
            REG_THRESHOLD:  thr_q  = val[POS_W-1:0];
            REG_LOW_THRESH: low_q  = val[POS_W-1:0];
            REG_GAIN:       gain_q = val[GAIN_W-1:0];
            REG_FORCED_VEL: fvel_q = val[FVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_sample(input int k, input int p, input bit s, input bit f);
        sample_word_t w;
        w.key           = KEY_W'(k);
        w.position      = POS_W'(p);
        w.hammer_strike = s;
        w.frame_end     = f;
        pending_samples.push_back(w);
    endtask

    // Next position of a key: dwell on one side of the threshold, then swap sides
    function automatic int trace_position(input int k);
        int t;
        t = int'(thr_q);
        if (trace_hold[k] == 0)
        begin
            trace_high[k] = !trace_high[k];
            trace_hold[k] = $urandom_range(18, 2);
        end
        else
            trace_hold[k]--;
        if ($urandom_range(9) == 0)
        begin
            t = trace_high[k] ? t + $urandom_range(3) : t - $urandom_range(3);
            return (t < 0) ? 0 : (t > 4095) ? 4095 : t;
        end
        if (trace_high[k])
            return $urandom_range(4095, t);
        return (t == 0) ? 0 : $urandom_range(t - 1, 0);
    endfunction

    task automatic queue_random_samples(input int count);
        int made;
        int sz;
        int r;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                queue_sample($urandom_range(15), $urandom_range(4095), $urandom_range(1),
                             $urandom_range(1));
                made++;
            end
            else
            begin
                // Mostly short frames so each key sees many frames; a few full ones
                sz = ($urandom_range(4) == 0) ? CHANNELS : $urandom_range(4, 1);
                for (int k = 0; k < sz; k++)
                begin
                    // Broken frames drop the frame end marker
                    queue_sample(k, trace_position(k), ($urandom_range(99) < 8),
                                 (k == sz - 1) && (r >= 17));
                    made++;
                end
            end
        end
    endtask

    task automatic run_setting(input bit en, input int thr, input int low, input int gain,
                               input int fvel, input int gap, input int stall);
        wait_drained();
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_LOW_THRESH, CFG_DATA_W'(low));
        write_reg(REG_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_FORCED_VEL, CFG_DATA_W'(fvel));
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        settings_run++;
        queue_random_samples(PHASE_WORDS);
    endtask

    initial begin
        error_count     = 0;
        words_sent      = 0;
        results_checked = 0;
        lifts_seen      = 0;
        damps_seen      = 0;
        forced_seen     = 0;
        settings_run    = 0;
        send_gap_pct    = 0;
        recv_stall_pct  = 0;
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at reset settings: field extremes and hammer latch cases
        queue_sample(0, 0, 1'b1, 1'b0);       // set latch
        queue_sample(0, 0, 1'b0, 1'b0);       // forced damp at position zero
        queue_sample(15, 4095, 1'b1, 1'b1);
        queue_sample(15, 4095, 1'b0, 1'b0);   // latched but damper still up
        queue_sample(15, 1637, 1'b0, 1'b1);   // just below low threshold: forced
        queue_sample(15, 1638, 1'b1, 1'b0);
        queue_sample(15, 1638, 1'b0, 1'b0);   // at low threshold: no force
        queue_sample(7, 2048, 1'b0, 1'b1);
        queue_sample(8, 2047, 1'b1, 1'b0);
        queue_sample(8, 4095, 1'b1, 1'b1);    // strike ignored while latched
        for (int k = 0; k < CHANNELS; k++)
            queue_sample(k, (k % 2) ? 4095 : 0, (k == 5), (k == CHANNELS - 1));

        run_setting(1'b1, 2048, 1638, 256, 3277, 0, 0);
        run_setting(1'b1, 4095, 4095, 65535, 32767, 51, 0);
        run_setting(1'b1, 0, 0, 0, 0, 0, 51);
        run_setting(1'b0, 2048, 2000, 1000, 16384, 18, 18);
        run_setting(1'b1, 1000, 500, 3000, 16384, 0, 0);
        run_setting(1'b1, $urandom_range(3500, 500), $urandom_range(4095), $urandom_range(65535),
                    $urandom_range(32767), 18, 18);
        run_setting(1'b1, $urandom_range(3500, 500), $urandom_range(4095), $urandom_range(65535),
                    $urandom_range(32767), 51, 0);
        run_setting(1'b1, 3000, 2500, 128, 1, 0, 51);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d words over %0d register settings.",
                 results_checked, words_sent, settings_run + 1);
        $display("Events seen: %0d lift, %0d damp, %0d of them forced.",
                 lifts_seen, damps_seen, forced_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", expected_events.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
